### rtl/core/trfd_pkg.sv
// trfd_pkg: shared constants for the table reciprocal divide core
// no dependencies
package trfd_pkg;
	localparam int INDEX_BITS = 10;
	localparam int WORD_BITS  = 36;
	localparam int FP_BITS    = 32;
	localparam logic OP_DIVIDE = 1'b0;
	localparam logic OP_WRITE  = 1'b1;
	localparam logic [7:0] REXP_BASE = 8'd254;
	localparam logic [8:0] EXP_BIAS  = 9'd129;
endpackage

### rtl/core/table_reciprocal_float_divide_core.sv
// table_reciprocal_float_divide_core: top level, table lookup, reciprocal, multiply
// depends on trfd_pkg, trfd_ram, trfd_mul
//
// input beats on s_axis carry an opcode in tuser and the operands in tdata.
// a write beat stores one reciprocal table word and yields no output beat.
// a divide beat yields one quotient beat on m_axis.
// pipeline: s1 table read, s2 gradient multiply, s3 reciprocal subtract,
// s4 partial products, s5 sum and normalize.
// throughput one beat per cycle while m_axis is not stalled.
// a stall on m_axis freezes the whole pipe; s_axis_tready drops with it,
// so nothing is lost or repeated.
// reset clears valid bits only; the table is undefined until written and
// a divide must only read entries already written.
// a write followed by a divide at the same entry is safe: the write lands
// in the ram before the later read.
// table words are written by the write beats, no separate config port.
module table_reciprocal_float_divide_core #(
	parameter int INDEX_BITS = trfd_pkg::INDEX_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // dividend, divisor, table_index, table_word, pad
	input  logic         s_axis_tuser,  // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata   // quotient
);
	localparam int FRAC_BITS = 23 - INDEX_BITS;
	localparam int DEPTH     = 1 << INDEX_BITS;

	logic        en, acc, is_div;
	logic [31:0] dividend, divisor;
	logic [9:0]  tindex;
	logic [35:0] tword, rword;
	logic [4:0]  v_q;
	logic [31:0] a_s1, a_s2, a_s3;
	logic [8:0]  hi_s1, hi_s2;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [22:0] cnst_s2;
	logic [25:0] prod_s2;
	logic [22:0] rmant;
	logic [31:0] recip_s3;
	logic [31:0] q;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign dividend      = s_axis_tdata[31:0];
	assign divisor       = s_axis_tdata[63:32];
	assign tindex        = s_axis_tdata[73:64];
	assign tword         = s_axis_tdata[109:74];
	assign is_div        = s_axis_tuser == trfd_pkg::OP_DIVIDE;

	trfd_ram #(.WIDTH(trfd_pkg::WORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (acc && s_axis_tuser == trfd_pkg::OP_WRITE),
		.waddr(INDEX_BITS'(tindex)),
		.wdata(tword),
		.re   (en),
		.raddr(divisor[22 -: INDEX_BITS]),
		.rdata(rword)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[3:0], acc && is_div};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= dividend;
			hi_s1   <= divisor[31:23];
			frac_s1 <= divisor[FRAC_BITS-1:0];
			a_s2    <= a_s1;
			hi_s2   <= hi_s1;
			cnst_s2 <= rword[22:0];
			prod_s2 <= 26'(rword[35:23] * 26'(frac_s1));
			a_s3    <= a_s2;
			recip_s3 <= {hi_s2[8], trfd_pkg::REXP_BASE - hi_s2[7:0], rmant};
		end
	end

	assign rmant = cnst_s2 - {7'd0, prod_s2[25:10]};

	trfd_mul u_mul (
		.clk(clk),
		.en (en),
		.a  (a_s3),
		.b  (recip_s3),
		.p  (q)
	);

	assign m_axis_tvalid = v_q[4];
	assign m_axis_tdata  = q;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q)) else $error("pipe moved during stall");
	a_write_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_div) |=> !v_q[0]) else $error("write beat produced valid");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("accepted during stall");
`endif
endmodule

### rtl/core/trfd_ram.sv
// trfd_ram: generic single-port-write, single-read ram with registered read
// depends on nothing
module trfd_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

### rtl/core/trfd_mul.sv
// trfd_mul: truncated float multiply, two register stages, advances on en
// depends on trfd_pkg
module trfd_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	logic [12:0] h1, h2;
	logic [10:0] l1, l2;
	logic [25:0] hh_s1, hl_s1, lh_s1;
	logic [8:0]  esum_s1;
	logic        sign_s1, zero_s1;
	logic [7:0]  ae, be;
	logic [8:0]  esum;
	logic [25:0] sum;
	logic [8:0]  esum1;

	assign ae = a[30:23];
	assign be = b[30:23];
	assign h1 = {1'b1, a[22:11]};
	assign l1 = a[10:0];
	assign h2 = {1'b1, b[22:11]};
	assign l2 = b[10:0];
	assign esum = {1'b0, ae} + {1'b0, be} + trfd_pkg::EXP_BIAS;

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1   <= h1 * h2;
			hl_s1   <= 26'((24'(h1) * 24'(l2)) >> 11);
			lh_s1   <= 26'((24'(l1) * 24'(h2)) >> 11);
			esum_s1 <= esum;
			sign_s1 <= a[31] ^ b[31];
			zero_s1 <= !esum[8] || ae == 8'd0 || be == 8'd0;
		end
	end

	assign sum   = hh_s1 + hl_s1 + lh_s1 + 26'd2;
	assign esum1 = esum_s1 + 9'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s1)
				p <= '0;
			else if (sum[25])
				p <= {sign_s1, esum1[7:0], sum[24:2]};
			else
				p <= {sign_s1, esum_s1[7:0], sum[23:1]};
		end
	end
endmodule

### dv/tb_table_reciprocal_float_divide_core.sv
// tb_table_reciprocal_float_divide_core: stream testbench for the table reciprocal divide core
// depends on trfd_pkg and table_reciprocal_float_divide_core; self-contained predictor
`timescale 1ns / 100ps

module tb_table_reciprocal_float_divide_core;

	localparam int INDEX_BITS = trfd_pkg::INDEX_BITS;
	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int FRAC  = 23 - INDEX_BITS;
	localparam int LIMIT = 20000;

	typedef struct packed {
		logic        op;
		logic [31:0] dividend;
		logic [31:0] divisor;
		logic [9:0]  index;
		logic [35:0] word;
	} beat_t;

	typedef struct {
		beat_t       b;
		logic        known;
		logic [31:0] q;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;

	logic [35:0] recip_words [DEPTH];
	bit          written [DEPTH];
	logic [31:0] quotients_due [$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          divides = 0;
	int          writes = 0;
	int          src_idle_pct = 13;
	int          dst_idle_pct = 56;
	bit          timed_out = 0;

	table_reciprocal_float_divide_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] reciprocal_of(logic [31:0] d);
		logic [35:0] w;
		logic [25:0] prod;
		logic [22:0] rm;
		w = recip_words[d[22:FRAC]];
		prod = w[35:23] * d[FRAC-1:0];
		rm = w[22:0] - {7'd0, prod[25:10]};
		return {d[31], trfd_pkg::REXP_BASE - d[30:23], rm};
	endfunction

	function automatic logic [31:0] quotient_of(logic [31:0] a, logic [31:0] d);
		logic [31:0] r;
		logic [23:0] m1, m2;
		logic [25:0] hh, hl, lh, sum;
		logic [8:0]  es, es1;
		r = reciprocal_of(d);
		m1 = {1'b1, a[22:0]};
		m2 = {1'b1, r[22:0]};
		hh = m1[23:11] * m2[23:11];
		hl = (m1[23:11] * m2[10:0]) >> 11;
		lh = (m1[10:0] * m2[23:11]) >> 11;
		sum = hh + hl + lh + 26'd2;
		es = {1'b0, a[30:23]} + {1'b0, r[30:23]} + trfd_pkg::EXP_BIAS;
		es1 = es + 9'd1;
		if (!es[8] || a[30:23] == 8'd0 || r[30:23] == 8'd0)
			return 32'd0;
		if (sum[25])
			return {a[31] ^ r[31], es1[7:0], sum[24:2]};
		return {a[31] ^ r[31], es[7:0], sum[23:1]};
	endfunction

	// predictor update on an accepted input beat
	task automatic absorb(beat_t b);
		if (b.op == trfd_pkg::OP_WRITE) begin
			recip_words[b.index[INDEX_BITS-1:0]] = b.word;
			written[b.index[INDEX_BITS-1:0]] = 1;
			writes++;
		end else begin
			quotients_due.push_back(quotient_of(b.dividend, b.divisor));
			divides++;
		end
	endtask

	task automatic send(beat_t b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= b.op;
		s_axis_tdata <= {2'b0, b.word, b.index, b.divisor, b.dividend};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		absorb(b);
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		release_bus();
		while (quotients_due.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_float(int mode);
		logic [31:0] f;
		f = $urandom;
		if (mode == 0)
			f[30:23] = 8'($urandom_range(100, 154));
		return f;
	endfunction

	// divisor whose table entry is already written
	function automatic logic [31:0] known_divisor(int mode);
		logic [31:0] f;
		f = rand_float(mode);
		while (!written[f[22:FRAC]])
			f[22:FRAC] = INDEX_BITS'($urandom_range(DEPTH - 1));
		return f;
	endfunction

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (quotients_due.size() == 0) begin
				$error("quotient: unexpected beat %h", m_axis_tdata);
				errors++;
			end else begin
				logic [31:0] want;
				want = quotients_due.pop_front();
				if (m_axis_tdata !== want) begin
					$error("quotient: expected %h actual %h", want, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb_table_reciprocal_float_divide_core: done, errors");
			$finish;
		end
	end

	row_t directed [$];

	initial begin
		beat_t b;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows: identity entry 0, full entry at the top index
		directed.push_back('{'{trfd_pkg::OP_WRITE, 32'd0, 32'd0, 10'd0, 36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_WRITE, 32'hffffffff, 32'hffffffff, 10'h3ff,
			36'hfffffffff}, 0, 32'd0});
		// 1.0 / 1.0 with zero table word
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h3f800000, 32'h3f800000, 10'd0,
			36'd0}, 0, 32'd0});
		// zero dividend exponent
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h007fffff, 32'h3f800000, 10'd0,
			36'd0}, 1, 32'd0});
		// divisor exponent 254 gives a zero reciprocal exponent
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h3f800000, 32'h7f000000, 10'd0,
			36'd0}, 1, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h00000000, 32'h00000000, 10'd0,
			36'd0}, 1, 32'd0});
		// underflow and overflow of the exponent sum
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h00800000, 32'h7e800000, 10'd0,
			36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h7f800000, 32'h00800000, 10'd0,
			36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'hffffffff, 32'hffffffff, 10'd0,
			36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h7fc00000, 32'hff800000, 10'd0,
			36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h40490fdb, 32'hc0000000, 10'd0,
			36'd0}, 0, 32'd0});
		// write then divide at the same entry
		directed.push_back('{'{trfd_pkg::OP_WRITE, 32'd0, 32'd0, 10'h155, 36'h0aaaa5555},
			0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'h3fc00000,
			{9'h07f, 10'h155, 13'h1fff}, 10'd0, 36'd0}, 0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_WRITE, 32'd0, 32'd0, 10'h2aa, 36'h955553aaa},
			0, 32'd0});
		directed.push_back('{'{trfd_pkg::OP_DIVIDE, 32'hbf7fffff,
			{9'h180, 10'h2aa, 13'h0aaa}, 10'd0, 36'd0}, 0, 32'd0});

		foreach (directed[i]) begin
			send(directed[i].b);
			if (directed[i].known && directed[i].b.op == trfd_pkg::OP_DIVIDE &&
				quotients_due[$] !== directed[i].q) begin
				$error("quotient: expected %h actual %h", directed[i].q, quotients_due[$]);
				errors++;
			end
		end
		// pause until the pipe is empty
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 56 : 0;
			dst_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 13 : 0;
			for (int n = 0; n < 330; n++) begin
				b = '0;
				b.dividend = rand_float($urandom_range(3) == 0);
				b.index = 10'($urandom);
				b.word = 36'({$urandom, $urandom});
				if ($urandom_range(99) < 25) begin
					b.op = trfd_pkg::OP_WRITE;
					b.divisor = $urandom;
				end else begin
					b.op = trfd_pkg::OP_DIVIDE;
					b.divisor = known_divisor($urandom_range(3) == 0);
				end
				send(b);
			end
			drain();
		end

		$display("covered %0d divides and %0d table writes over three idle mixes",
			divides, writes);
		if (errors == 0)
			$display("tb_table_reciprocal_float_divide_core: done, clean");
		else
			$display("tb_table_reciprocal_float_divide_core: done, errors");
		$finish;
	end
endmodule

### files.f
rtl/core/trfd_pkg.sv
rtl/core/trfd_ram.sv
rtl/core/trfd_mul.sv
rtl/core/table_reciprocal_float_divide_core.sv
dv/tb_table_reciprocal_float_divide_core.sv
